>>> sv/gcdn_pkg.sv
// Shared constants, payload types and helpers for the Gray-code digital net generator.
`default_nettype none

package gcdn_pkg;

  localparam int MAX_DIMS  = 32;
  localparam int MAX_BITS  = 32;
  localparam int DIM_W     = $clog2(MAX_DIMS);
  localparam int BIT_W     = $clog2(MAX_BITS);
  localparam int MAT_AW    = DIM_W + BIT_W;
  localparam int WORD_W    = 32;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 1;
  localparam int KIND_W    = 2;

  localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
  localparam logic [KIND_W-1:0] KIND_NEXT    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_DIMS_IN_USE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BITS_IN_USE = 1'd1;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [DIM_W-1:0]  dim_index;
    logic [BIT_W-1:0]  bit_index;
    logic [WORD_W-1:0] matrix_word;
  } in_item_t;

  typedef struct packed {
    logic [DIM_W-1:0]  coord_dim;
    logic [WORD_W-1:0] coord_value;
    logic              last;
    logic              exhausted;
  } out_item_t;

  // write request into the generator matrix store
  typedef struct packed {
    logic              en;
    logic [MAT_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } mat_wr_t;

  // read/write/clear requests into the coordinate store
  typedef struct packed {
    logic              clr;
    logic              rd_en;
    logic [DIM_W-1:0]  rd_addr;
    logic              wr_en;
    logic [DIM_W-1:0]  wr_addr;
    logic [WORD_W-1:0] wr_data;
  } coord_req_t;

  // trailing zero count of a non-zero word, binary search in five steps
  function automatic logic [BIT_W-1:0] tz32(input logic [WORD_W-1:0] v);
    logic [WORD_W-1:0] x;
    logic [BIT_W-1:0]  n;
    x = v;
    n = '0;
    if (x[15:0] == 16'd0) begin
      n[4] = 1'b1;
      x = x >> 16;
    end
    if (x[7:0] == 8'd0) begin
      n[3] = 1'b1;
      x = x >> 8;
    end
    if (x[3:0] == 4'd0) begin
      n[2] = 1'b1;
      x = x >> 4;
    end
    if (x[1:0] == 2'd0) begin
      n[1] = 1'b1;
      x = x >> 2;
    end
    if (x[0] == 1'b0) begin
      n[0] = 1'b1;
    end
    return n;
  endfunction

endpackage

`default_nettype wire

>>> sv/gcdn_matrix_ram.sv
// Generator matrix store: one column word per dimension and Gray bit, single write, single read.
`default_nettype none

module gcdn_matrix_ram
  import gcdn_pkg::*;
(
  input  wire logic              clk,
  input  wire mat_wr_t           wr,
  input  wire logic              rd_en,
  input  wire logic [MAT_AW-1:0] rd_addr,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0] mem [MAX_DIMS*MAX_BITS];
  logic [WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

>>> sv/gcdn_coord_ram.sv
// Coordinate store of the current point, with per-entry valid bits so restart clears at once.
`default_nettype none

module gcdn_coord_ram
  import gcdn_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire coord_req_t        req,
  output logic      [WORD_W-1:0] rd_data
);

  logic [WORD_W-1:0]   mem [MAX_DIMS];
  logic [MAX_DIMS-1:0] vld_r;
  logic [MAX_DIMS-1:0] vld_nxt;
  logic [WORD_W-1:0]   rd_data_r;
  logic                rd_vld_r;

  always_comb begin
    vld_nxt = vld_r;
    if (req.clr) begin
      vld_nxt = '0;
    end else if (req.wr_en) begin
      vld_nxt[req.wr_addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
      rd_vld_r  <= vld_r[req.rd_addr];
    end
  end

  // an entry not written since the last restart reads as zero
  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

`default_nettype wire

>>> sv/gray_code_digital_net_generator_core.sv
// Top level: item decode, point counter and the read-modify-write sequencer over both stores.
//
// Usage. Items arrive on in_valid/in_stall/in_item and are taken on an edge with in_valid
// high and in_stall low. A load item writes one generator column word; a restart item
// clears the point and the counter; both give no result. A next item advances the counter
// and XORs the selected column into each coordinate, giving dims_in_use results on
// out_valid/out_stall/out_item, the final one marked last. Once the 2^bits_in_use - 1
// points are used a next item gives a single result flagged exhausted. in_stall is high
// while a next item is in progress; one read of each store is issued per dimension, one
// per cycle while the read stage can advance, and the reads are registered before the
// output register. The output register lets the last result wait while the next item is
// taken. An out_stall holds the output register and stops further store reads once the
// read stage is full, so nothing is lost. Config (cfg_we, cfg_idx, cfg_data) must be
// written only while the block is idle; the block itself does not enforce this. Reset clears
// the point, the counter, dims_in_use and bits_in_use (both to 1); the matrix is undefined
// until loaded.
`default_nettype none

module gray_code_digital_net_generator_core
  import gcdn_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_item,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [CFG_W-1:0]  dims_r, dims_nxt;
  logic [CFG_W-1:0]  bits_r, bits_nxt;
  logic [WORD_W-1:0] cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              exh_r, exh_nxt;
  logic [BIT_W-1:0]  col_r, col_nxt;
  logic [DIM_W-1:0]  dlast_r, dlast_nxt;
  logic [DIM_W-1:0]  iss_r, iss_nxt;
  logic              iss_done_r, iss_done_nxt;
  logic              b_vld_r, b_vld_nxt;
  logic [DIM_W-1:0]  b_dim_r, b_dim_nxt;
  logic              b_last_r, b_last_nxt;
  logic              b_exh_r, b_exh_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_item_t         out_item_r, out_item_nxt;

  logic              accept;
  logic [CFG_W-1:0]  eff_dims, eff_bits, dlast_w;
  logic [WORD_W:0]   lim_wide;
  logic              at_limit;
  logic              out_free, b_adv, issue, issue_last;
  logic [WORD_W-1:0] mat_rd, coord_rd, coord_new;
  mat_wr_t           mat_wr;
  coord_req_t        coord_req;

  assign accept   = in_valid && !busy_r;
  assign in_stall = busy_r;

  // effective register values
  always_comb begin
    priority if (dims_r == '0) begin
      eff_dims = CFG_W'(1);
    end else if (dims_r > CFG_W'(MAX_DIMS)) begin
      eff_dims = CFG_W'(MAX_DIMS);
    end else begin
      eff_dims = dims_r;
    end
    priority if (bits_r == '0) begin
      eff_bits = CFG_W'(1);
    end else if (bits_r > CFG_W'(MAX_BITS)) begin
      eff_bits = CFG_W'(MAX_BITS);
    end else begin
      eff_bits = bits_r;
    end
  end

  assign dlast_w  = eff_dims - CFG_W'(1);
  assign lim_wide = ({{WORD_W{1'b0}}, 1'b1} << eff_bits) - {{WORD_W{1'b0}}, 1'b1};
  assign at_limit = cnt_r >= lim_wide[WORD_W-1:0];

  assign out_free   = !out_vld_r || !out_stall;
  assign b_adv      = b_vld_r && out_free;
  assign issue      = busy_r && !iss_done_r && (!b_vld_r || b_adv);
  assign issue_last = exh_r || (iss_r == dlast_r);
  assign coord_new  = coord_rd ^ mat_rd;

  always_comb begin
    mat_wr.en   = accept && (in_item.kind == KIND_LOAD);
    mat_wr.addr = {in_item.dim_index, in_item.bit_index};
    mat_wr.data = in_item.matrix_word;

    coord_req.clr     = accept && (in_item.kind == KIND_RESTART);
    coord_req.rd_en   = issue;
    coord_req.rd_addr = iss_r;
    coord_req.wr_en   = b_adv && !b_exh_r;
    coord_req.wr_addr = b_dim_r;
    coord_req.wr_data = coord_new;
  end

  gcdn_matrix_ram u_matrix (
    .clk     (clk),
    .wr      (mat_wr),
    .rd_en   (issue),
    .rd_addr ({iss_r, col_r}),
    .rd_data (mat_rd)
  );

  gcdn_coord_ram u_coord (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (coord_req),
    .rd_data (coord_rd)
  );

  always_comb begin
    dims_nxt     = dims_r;
    bits_nxt     = bits_r;
    cnt_nxt      = cnt_r;
    busy_nxt     = busy_r;
    exh_nxt      = exh_r;
    col_nxt      = col_r;
    dlast_nxt    = dlast_r;
    iss_nxt      = iss_r;
    iss_done_nxt = iss_done_r;
    b_vld_nxt    = b_vld_r;
    b_dim_nxt    = b_dim_r;
    b_last_nxt   = b_last_r;
    b_exh_nxt    = b_exh_r;
    out_vld_nxt  = out_vld_r;
    out_item_nxt = out_item_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_DIMS_IN_USE: dims_nxt = cfg_data;
        CFG_BITS_IN_USE: bits_nxt = cfg_data;
        default: ;
      endcase
    end

    if (accept) begin
      unique case (in_item.kind)
        KIND_RESTART: cnt_nxt = '0;
        KIND_NEXT: begin
          busy_nxt     = 1'b1;
          exh_nxt      = at_limit;
          iss_nxt      = '0;
          iss_done_nxt = 1'b0;
          dlast_nxt    = dlast_w[DIM_W-1:0];
          if (!at_limit) begin
            cnt_nxt = cnt_r + WORD_W'(1);
            // changed Gray bit: trailing ones of the old count
            col_nxt = tz32(~cnt_r);
          end
        end
        KIND_LOAD, KIND_UNUSED: ;
        default: ;
      endcase
    end

    if (issue) begin
      iss_nxt      = iss_r + DIM_W'(1);
      iss_done_nxt = issue_last;
      b_dim_nxt    = iss_r;
      b_last_nxt   = issue_last;
      b_exh_nxt    = exh_r;
    end

    if (issue) begin
      b_vld_nxt = 1'b1;
    end else if (b_adv) begin
      b_vld_nxt = 1'b0;
    end

    if (b_adv) begin
      out_vld_nxt              = 1'b1;
      out_item_nxt.coord_dim   = b_exh_r ? '0 : b_dim_r;
      out_item_nxt.coord_value = b_exh_r ? '0 : coord_new;
      out_item_nxt.last        = b_last_r;
      out_item_nxt.exhausted   = b_exh_r;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end

    if (busy_r && iss_done_r && (b_adv || !b_vld_r)) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r     <= CFG_W'(1);
      bits_r     <= CFG_W'(1);
      cnt_r      <= '0;
      busy_r     <= 1'b0;
      iss_done_r <= 1'b0;
      b_vld_r    <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      dims_r     <= dims_nxt;
      bits_r     <= bits_nxt;
      cnt_r      <= cnt_nxt;
      busy_r     <= busy_nxt;
      iss_done_r <= iss_done_nxt;
      b_vld_r    <= b_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    exh_r      <= exh_nxt;
    col_r      <= col_nxt;
    dlast_r    <= dlast_nxt;
    iss_r      <= iss_nxt;
    b_dim_r    <= b_dim_nxt;
    b_last_r   <= b_last_nxt;
    b_exh_r    <= b_exh_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
